### rtl/core/mt19937_keystream_xor_cipher_core_macros.svh
// Assertion macros used by the keystream cipher controller RTL.
`ifndef MT19937_KEYSTREAM_XOR_CIPHER_CORE_MACROS_SVH
`define MT19937_KEYSTREAM_XOR_CIPHER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Plain property check, disabled during reset.
`define MTXC_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("mtxc assertion failed");

// Next-cycle implication, disabled during reset.
`define MTXC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("mtxc assertion failed");

`else

`define MTXC_ASSERT(lbl, clk, rstn, prop)
`define MTXC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

### rtl/core/mtxc_pkg.sv
// Shared constants, state encoding and control types for the keystream cipher.
`default_nettype none

package mtxc_pkg;

	localparam int unsigned STATE_WORDS   = 624;
	localparam int unsigned SHIFT_WORDS   = 397;
	localparam int unsigned IDX_W         = $clog2(STATE_WORDS);
	localparam logic [31:0] MT_MATRIX     = 32'h9908_b0df;
	localparam logic [31:0] MT_INIT_MULT  = 32'd1812433253;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SEED_MUL = 6'b000010,
		ST_SEED_ADD = 6'b000100,
		ST_RD_J     = 6'b001000,
		ST_RD_K     = 6'b010000,
		ST_WR       = 6'b100000
	} state_t;

	typedef struct packed {
		logic load_item;
		logic seed_start;
		logic seed_mul;
		logic seed_add;
		logic rd_j;
		logic rd_k;
		logic wr;
	} cmd_t;

	typedef struct packed {
		logic seed_done;
	} sts_t;

endpackage

`default_nettype wire

### rtl/core/mtxc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mtxc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 624
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/mtxc_datapath.sv
// Datapath: seed register, state memory, seeding arithmetic, twist, temper and output byte.
`default_nettype none

module mtxc_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mtxc_pkg::cmd_t cmd,
	output mtxc_pkg::sts_t     sts,
	input  wire logic          seed_we,
	input  wire logic [31:0]   seed_wdata,
	input  wire logic [7:0]    data_byte,
	input  wire logic          last_in,
	output logic      [7:0]    out_byte,
	output logic               last_out
);
	import mtxc_pkg::*;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] t;
		t = w ^ (w >> 11);
		t = t ^ ((t << 7) & 32'h9d2c_5680);
		t = t ^ ((t << 15) & 32'hefc6_0000);
		t = t ^ (t >> 18);
		return t;
	endfunction

	logic [31:0] seed_q;
	idx_t        idx_q;      // word to twist next
	idx_t        sidx_q;     // seeding position
	logic [31:0] prev_q;
	logic [31:0] prod_q;
	logic [31:0] cur_q;      // copy of word idx_q
	logic [31:0] nxt_q;      // copy of word idx_q + 1
	logic [7:0]  data_q;
	logic        last_q;
	logic [7:0]  out_byte_q;
	logic        last_out_q;

	idx_t           j_idx;
	idx_t           k_idx;
	logic [IDX_W:0] k_sum;
	idx_t           raddr;
	logic [31:0]    rdata;
	logic           we;
	idx_t           waddr;
	logic [31:0]    wdata;
	logic [31:0]    y;
	logic [31:0]    twisted;
	logic [31:0]    seed_word;
	logic [31:0]    ks;

	assign j_idx = (idx_q == LAST_IDX) ? '0 : idx_q + idx_t'(1);
	assign k_sum = {1'b0, idx_q} + (IDX_W+1)'(SHIFT_WORDS);
	assign k_idx = (k_sum >= (IDX_W+1)'(STATE_WORDS)) ?
		IDX_W'(k_sum - (IDX_W+1)'(STATE_WORDS)) : k_sum[IDX_W-1:0];

	assign raddr = cmd.rd_j ? j_idx : k_idx;

	// rdata holds word k during the write cycle
	assign y         = {cur_q[31], nxt_q[30:0]};
	assign twisted   = rdata ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'h0);
	assign seed_word = prod_q + {{(32-IDX_W){1'b0}}, sidx_q};
	assign ks        = temper(twisted);

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = twisted;
		if (cmd.seed_start) begin
			we    = 1'b1;
			waddr = '0;
			wdata = seed_q;
		end else if (cmd.seed_add) begin
			we    = 1'b1;
			waddr = sidx_q;
			wdata = seed_word;
		end else if (cmd.wr) begin
			we = 1'b1;
		end
	end

	mtxc_ram #(
		.WIDTH(32),
		.DEPTH(STATE_WORDS)
	) u_state_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign sts.seed_done = (sidx_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			idx_q  <= '0;
			sidx_q <= '0;
		end else begin
			if (seed_we) begin
				seed_q <= seed_wdata;
			end
			if (cmd.seed_start) begin
				idx_q  <= '0;
				sidx_q <= idx_t'(1);
			end else if (cmd.seed_add && !sts.seed_done) begin
				sidx_q <= sidx_q + idx_t'(1);
			end else if (cmd.wr) begin
				idx_q <= j_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			data_q <= data_byte;
			last_q <= last_in;
		end
		if (cmd.seed_start) begin
			prev_q <= seed_q;
			cur_q  <= seed_q;
		end
		if (cmd.seed_mul) begin
			prod_q <= MT_INIT_MULT * (prev_q ^ (prev_q >> 30));
		end
		if (cmd.seed_add) begin
			prev_q <= seed_word;
		end
		if (cmd.rd_k) begin
			nxt_q <= rdata;
		end
		if (cmd.wr) begin
			cur_q      <= nxt_q;
			out_byte_q <= data_q ^ ks[7:0];
			last_out_q <= last_q;
		end
	end

	assign out_byte = out_byte_q;
	assign last_out = last_out_q;

endmodule

`default_nettype wire

### rtl/core/mtxc_ctrl.sv
// Controller: sequences seeding and per-word twist, owns the handshakes.
`default_nettype none

`include "mt19937_keystream_xor_cipher_core_macros.svh"

module mtxc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic           restart,
	output logic                out_valid,
	input  wire logic           out_ready,
	output mtxc_pkg::cmd_t      cmd,
	input  wire mtxc_pkg::sts_t sts
);
	import mtxc_pkg::*;

	state_t st_q;
	state_t st_nxt;
	logic   engine_ready_q;
	logic   out_valid_q;

	always_comb begin
		st_nxt   = st_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.rd_j = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					if (restart || !engine_ready_q) begin
						cmd.seed_start = 1'b1;
						st_nxt         = ST_SEED_MUL;
					end else begin
						// read of word j already issued this cycle
						st_nxt = ST_RD_K;
					end
				end
			end
			ST_SEED_MUL: begin
				cmd.seed_mul = 1'b1;
				st_nxt       = ST_SEED_ADD;
			end
			ST_SEED_ADD: begin
				cmd.seed_add = 1'b1;
				st_nxt       = sts.seed_done ? ST_RD_J : ST_SEED_MUL;
			end
			ST_RD_J: begin
				cmd.rd_j = 1'b1;
				st_nxt   = ST_RD_K;
			end
			ST_RD_K: begin
				cmd.rd_k = 1'b1;
				st_nxt   = ST_WR;
			end
			ST_WR: begin
				if (!out_valid_q || out_ready) begin
					cmd.wr = 1'b1;
					st_nxt = ST_IDLE;
				end
			end
			default: begin
				st_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= ST_IDLE;
			engine_ready_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (cmd.seed_start) begin
				engine_ready_q <= 1'b0;
			end else if (cmd.seed_add && sts.seed_done) begin
				engine_ready_q <= 1'b1;
			end
			if (cmd.wr) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`MTXC_ASSERT_NEXT(a_wr_holds_on_stall, clk, arst_n, st_q == ST_WR && out_valid_q && !out_ready, st_q == ST_WR && out_valid_q)
	`MTXC_ASSERT_NEXT(a_seed_done_ready, clk, arst_n, st_q == ST_SEED_ADD && sts.seed_done, engine_ready_q && st_q == ST_RD_J)
	`MTXC_ASSERT_NEXT(a_restart_reseeds, clk, arst_n, in_valid && in_ready && restart, st_q == ST_SEED_MUL && !engine_ready_q)
	`MTXC_ASSERT(a_twist_needs_seed, clk, arst_n, !(cmd.rd_k || cmd.wr) || engine_ready_q)

endmodule

`default_nettype wire

### rtl/core/mt19937_keystream_xor_cipher_core.sv
// Top level: MT19937 keystream XOR byte cipher.
//
//  channel | signals                                 | handshake
//  --------+-----------------------------------------+----------------------
//  in      | data_byte[7:0], restart, last_in        | in_valid / in_ready
//  out     | out_byte[7:0], last_out                 | out_valid / out_ready
//  config  | seed_wdata[31:0]                        | seed_we, no wait
//
// A seeded byte reads word i+1 as it is accepted, then word i+397, then twists,
// tempers and writes; the single read port of the state memory sets this order.
// Reset leaves the engine unseeded; a seeding byte (first after reset, or restart)
// writes the seed as word 0, then 623 more words by a multiply and an add on the
// one init multiplier, then as above. A new byte is accepted while the previous
// result waits at the output; a stall holds the next result in its write cycle.
`default_nettype none

module mt19937_keystream_xor_cipher_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_we,
	input  wire logic [31:0] seed_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        restart,
	input  wire logic        last_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [7:0]  out_byte,
	output logic             last_out
);
	import mtxc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mtxc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.restart  (restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	mtxc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.seed_we   (seed_we),
		.seed_wdata(seed_wdata),
		.data_byte (data_byte),
		.last_in   (last_in),
		.out_byte  (out_byte),
		.last_out  (last_out)
	);

endmodule

`default_nettype wire
